@@ hdl/ieval_pkg.sv @@
// Shared constants, types and codes for the infix expression evaluator.
`default_nettype none
package ieval_pkg;
  localparam int VW          = 32;
  localparam int MAX_NESTING = 16;
  localparam int AW          = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int DW          = $clog2(MAX_NESTING + 1);
  localparam int OPS_W       = 4;
  localparam int SLOT_W      = 2 * VW + OPS_W;
  localparam int CW          = $clog2(VW + 1);

  localparam int OP_SUB = 0;
  localparam int OP_DIV = 1;
  localparam int OP_NEG = 2;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [1:0] {PH_OPERAND, PH_AFTER_NEG, PH_NUMBER, PH_AFTER} phase_t;
  typedef enum logic [1:0] {ERR_NONE, ERR_SYNTAX, ERR_DIV0, ERR_DEPTH} err_t;
  typedef enum logic [2:0] {
    DP_NOP, DP_LATCH, DP_DECODE, DP_APPLY, DP_DIV_DONE, DP_POP, DP_LAST, DP_EMIT
  } dp_op_t;
  typedef enum logic [1:0] {DEC_DONE, DEC_APPLY, DEC_POP} dec_t;
  typedef enum logic [1:0] {CONT_CHAR, CONT_END, CONT_LAST} cont_t;
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_APPLY, S_DIV, S_POP, S_END, S_LAST, S_FIN
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    dec_t          dec;
    logic          last;
    logic          div_go;
    logic          div_done;
    logic          last_apply;
    logic          out_free;
    logic [DW-1:0] depth;
  } dp_stat_t;
endpackage
`default_nettype wire

@@ hdl/ieval_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ieval_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ hdl/ieval_div.sv @@
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
`default_nettype none
module ieval_div
  import ieval_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [VW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic      [VW-1:0] quotient
);
  logic [VW-1:0] rem;
  logic [VW-1:0] quo;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          run;
  logic          neg;
  logic [VW:0]   sh;
  logic          ge;

  assign sh       = {rem, quo[VW-1]};
  assign ge       = sh >= {1'b0, dvs};
  assign quotient = neg ? (VW'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(VW);
        rem <= '0;
        quo <= dividend[VW-1] ? (VW'(0) - dividend) : dividend;
        dvs <= divisor[VW-1] ? (VW'(0) - divisor) : divisor;
        neg <= dividend[VW-1] ^ divisor[VW-1];
      end else if (run) begin
        rem <= ge ? VW'(sh - {1'b0, dvs}) : sh[VW-1:0];
        quo <= {quo[VW-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/ieval_dp.sv @@
// Evaluator datapath: level registers, frame stack, divider and result register.
`default_nettype none
module ieval_dp
  import ieval_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dp_cmd_t       cmd,
  output dp_stat_t           stat,
  input  wire logic [7:0]    char_code,
  input  wire logic          last_char,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic signed [31:0] value,
  output logic        [1:0]  error_code
);
  logic [7:0]       ch;
  logic             last;
  logic [VW-1:0]    sum;
  logic [VW-1:0]    prod;
  logic [VW-1:0]    acc;
  logic [VW-1:0]    opnd;
  logic [2:0]       ops;
  phase_t           phase;
  logic [DW-1:0]    depth;
  err_t             err;

  logic             is_digit;
  logic             is_ws;
  logic [VW-1:0]    dig;
  logic [VW-1:0]    fold_v;
  logic [VW-1:0]    fneg;
  dec_t             dec;
  logic             push;
  logic [SLOT_W-1:0] rd_slot;
  logic             div_start;
  logic             div_done;
  logic [VW-1:0]    div_q;
  logic             out_free;

  assign is_digit = (ch >= CH_0) && (ch <= CH_9);
  assign is_ws    = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign dig      = VW'(ch - CH_0);
  assign fold_v   = ops[OP_SUB] ? (sum - prod) : (sum + prod);
  assign fneg     = ops[OP_NEG] ? (VW'(0) - opnd) : opnd;
  assign out_free = !out_valid || !out_stall;
  assign div_start = (cmd.op == DP_APPLY) && ops[OP_DIV] && (fneg != '0);
  assign push = (cmd.op == DP_DECODE) && (err == ERR_NONE) && !is_ws
                && (phase != PH_NUMBER) && (phase != PH_AFTER) && !is_digit
                && !(ch == CH_MINUS && phase == PH_OPERAND)
                && (ch == CH_LPAR) && (depth < DW'(MAX_NESTING));

  always_comb begin
    dec = DEC_DONE;
    if (err == ERR_NONE && !is_ws) begin
      if (phase == PH_NUMBER && !is_digit) begin
        dec = DEC_APPLY;
      end else if (phase == PH_AFTER && ch == CH_RPAR && depth != '0) begin
        dec = DEC_POP;
      end
    end
  end

  always_comb begin
    stat.dec        = dec;
    stat.last       = last;
    stat.div_go     = ops[OP_DIV] && (fneg != '0);
    stat.div_done   = div_done;
    stat.last_apply = (err == ERR_NONE) && (phase == PH_NUMBER);
    stat.out_free   = out_free;
    stat.depth      = depth;
  end

  ieval_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NESTING)) u_stack (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (depth[AW-1:0]),
    .wr_data ({sum, prod, 1'b0, ops}),
    .rd_addr (AW'(depth - DW'(1))),
    .rd_data (rd_slot)
  );

  ieval_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (fneg),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      prod      <= VW'(1);
      acc       <= '0;
      ops       <= '0;
      phase     <= PH_OPERAND;
      depth     <= '0;
      err       <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && cmd.op != DP_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        DP_NOP: begin
        end
        DP_LATCH: begin
          ch   <= char_code;
          last <= last_char;
        end
        DP_DECODE: begin
          if (err == ERR_NONE && !is_ws) begin
            unique case (phase)
              PH_NUMBER: begin
                if (is_digit) begin
                  acc <= VW'(acc * VW'(10)) + dig;
                end else begin
                  opnd  <= acc;
                  phase <= PH_AFTER;
                end
              end
              PH_AFTER: begin
                if (ch == CH_STAR || ch == CH_SLASH) begin
                  ops[OP_DIV] <= (ch == CH_SLASH);
                  phase       <= PH_OPERAND;
                end else if (ch == CH_PLUS || ch == CH_MINUS) begin
                  sum   <= fold_v;
                  prod  <= VW'(1);
                  ops   <= {2'b00, ch == CH_MINUS};
                  phase <= PH_OPERAND;
                end else if (ch == CH_RPAR && depth != '0) begin
                  opnd  <= fold_v;
                  depth <= depth - DW'(1);
                end else begin
                  err <= ERR_SYNTAX;
                end
              end
              default: begin
                if (ch == CH_MINUS && phase == PH_OPERAND) begin
                  ops[OP_NEG] <= 1'b1;
                  phase       <= PH_AFTER_NEG;
                end else if (is_digit) begin
                  acc   <= dig;
                  phase <= PH_NUMBER;
                end else if (ch == CH_LPAR) begin
                  if (depth >= DW'(MAX_NESTING)) begin
                    err <= ERR_DEPTH;
                  end else begin
                    depth <= depth + DW'(1);
                    sum   <= '0;
                    prod  <= VW'(1);
                    ops   <= '0;
                    phase <= PH_OPERAND;
                  end
                end else begin
                  err <= ERR_SYNTAX;
                end
              end
            endcase
          end
        end
        DP_APPLY: begin
          if (ops[OP_DIV]) begin
            if (fneg == '0) begin
              err <= ERR_DIV0;
            end
          end else begin
            prod        <= VW'(prod * fneg);
            ops[OP_DIV] <= 1'b0;
            ops[OP_NEG] <= 1'b0;
          end
        end
        DP_DIV_DONE: begin
          prod        <= div_q;
          ops[OP_DIV] <= 1'b0;
          ops[OP_NEG] <= 1'b0;
        end
        DP_POP: begin
          sum  <= rd_slot[SLOT_W-1 -: VW];
          prod <= rd_slot[VW+OPS_W-1 -: VW];
          ops  <= rd_slot[2:0];
        end
        DP_LAST: begin
          if (err == ERR_NONE && phase == PH_NUMBER) begin
            opnd  <= acc;
            phase <= PH_AFTER;
          end
        end
        DP_EMIT: begin
          out_valid <= 1'b1;
          if (err != ERR_NONE) begin
            error_code <= err;
            value      <= '0;
          end else if (phase == PH_AFTER && depth == '0) begin
            error_code <= ERR_NONE;
            value      <= signed'(32'(fold_v));
          end else begin
            error_code <= ERR_SYNTAX;
            value      <= '0;
          end
          sum   <= '0;
          prod  <= VW'(1);
          acc   <= '0;
          ops   <= '0;
          phase <= PH_OPERAND;
          depth <= '0;
          err   <= ERR_NONE;
        end
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hdl/ieval_ctrl.sv @@
// Evaluator controller: sequences decode, factor application, pops and results.
`default_nettype none
module ieval_ctrl
  import ieval_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);
  state_t state, state_next;
  cont_t  cont, cont_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cont  <= CONT_END;
    end else begin
      state <= state_next;
      cont  <= cont_next;
    end
  end

  always_comb begin
    state_next = state;
    cont_next  = cont;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.dec)
          DEC_APPLY: begin
            state_next = S_APPLY;
            cont_next  = CONT_CHAR;
          end
          DEC_POP: state_next = S_POP;
          default: state_next = S_END;
        endcase
      end
      S_POP: begin
        state_next = S_APPLY;
        cont_next  = CONT_END;
      end
      S_APPLY, S_DIV: begin
        if ((state == S_APPLY && !stat.div_go) || (state == S_DIV && stat.div_done)) begin
          unique case (cont)
            CONT_CHAR: state_next = S_DECODE;
            CONT_LAST: state_next = S_FIN;
            default:   state_next = S_END;
          endcase
        end else if (state == S_APPLY) begin
          state_next = S_DIV;
        end
      end
      S_END: begin
        state_next = stat.last ? S_LAST : S_IDLE;
      end
      S_LAST: begin
        if (stat.last_apply) begin
          state_next = S_APPLY;
          cont_next  = CONT_LAST;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    cmd.op   = DP_NOP;
    unique case (state)
      S_IDLE:   if (in_valid) cmd.op = DP_LATCH;
      S_DECODE: cmd.op = DP_DECODE;
      S_POP:    cmd.op = DP_POP;
      S_APPLY:  cmd.op = DP_APPLY;
      S_DIV:    if (stat.div_done) cmd.op = DP_DIV_DONE;
      S_LAST:   cmd.op = DP_LAST;
      S_FIN:    if (stat.out_free) cmd.op = DP_EMIT;
      default:  cmd.op = DP_NOP;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/infix_integer_expression_evaluator.sv @@
// Top level of the streaming infix integer expression evaluator.
// Usage: feed one ASCII character per item on the input channel (char_code,
// last_char) with in_valid/in_stall; an item is taken when in_valid is high
// and in_stall is low. Each expression ends on an item with last_char set,
// which yields one result item (value, error_code) on the output channel,
// taken when out_valid is high and out_stall is low.
// Sequence: a plain character passes through accept, decode and finish, and
// no new character is taken before the last one is through. Applying a
// factor adds an apply step, and for a divide a wait on the iterative
// divider; closing a number also decodes the character again, and a pop
// adds a frame stack read. A ')' right after a number may apply two divides.
// The last character adds last and emit steps, any final factor and output wait.
// The result waits in an output register; the next expression is accepted
// while it waits, and only its own result stalls behind an unaccepted one.
// Reset is synchronous: it empties the output, clears the current expression
// and returns the block to taking input in the next cycle.
`default_nettype none
module infix_integer_expression_evaluator
  import ieval_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic         [7:0] char_code,
  input  wire logic               last_char,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [31:0] value,
  output logic              [1:0] error_code
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  ieval_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ieval_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .char_code  (char_code),
    .last_char  (last_char),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .value      (value),
    .error_code (error_code)
  );

`ifndef SYNTHESIS
  a_err_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != 2'd0 |-> value == 32'sd0)
    else $error("nonzero value with error");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    stat.depth <= DW'(MAX_NESTING))
    else $error("nesting depth out of range");
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not clean after reset");
`endif
endmodule
`default_nettype wire
